[src/assert_macros.svh]
// assertion helpers, compiled out when SYNTH is defined
// the enclosing module must provide aclk and aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define HPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPS_ASSERT(lbl, prop)
`define HPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/hps_pkg.sv]
package hps_pkg;

    localparam int PATTERN_STEPS = 512;
    localparam int IDX_W = $clog2(PATTERN_STEPS);
    localparam int POS_W = $clog2(PATTERN_STEPS + 1);

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_LOAD    = 3'd1;
    localparam logic [2:0] REQ_START   = 3'd2;
    localparam logic [2:0] REQ_ONESHOT = 3'd3;
    localparam logic [2:0] REQ_LEVEL   = 3'd4;

    localparam logic CFG_MAX_TIMEOUT = 1'b0;
    localparam logic CFG_LEVEL_MAX   = 1'b1;

    localparam logic [15:0] MAX_TIMEOUT_RST = 16'd15000;
    localparam logic [7:0]  LEVEL_MAX_RST   = 8'd128;
    localparam logic [7:0]  LEVEL_RST       = 8'd120;
    localparam logic [7:0]  DUR_OFFSET      = 8'd10;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] duration;
    } step_entry_t;

    typedef struct packed {
        logic        motor_on;
        logic [7:0]  duty_level;
        logic [15:0] remaining_ms;
        logic [9:0]  step_position;
    } result_t;

endpackage

[src/haptic_pattern_sequencer_unit.sv]
// Haptic pattern sequencer. Takes one event per clock while s_ready is high (tick, load
// step, start sequence, one-shot, set level) and returns one registered result per event
// through a two-entry output buffer so input keeps flowing while a result
// waits. Steps live in a 512-entry single-write pattern memory; the entry at the
// current play position is read ahead into a prefetch register (with
// write forwarding), and step 0 is mirrored in a register for sequence starts, so
// any event sequence runs at one item per cycle unless s_ready is low. Memory contents
// are undefined until loaded and no clearing pass runs after reset. Config writes (index 0
// max timeout, index 1 level max) take effect on the next cycle and belong between transfers.
`include "assert_macros.svh"

module haptic_pattern_sequencer_unit
    import hps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [8:0]  s_step_index,
    input  logic [7:0]  s_step_level,
    input  logic [7:0]  s_step_duration,
    input  logic [9:0]  s_seq_length,
    input  logic [15:0] s_on_time_ms,
    input  logic [7:0]  s_level_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_motor_on,
    output logic [7:0]  m_duty_level,
    output logic [15:0] m_remaining_ms,
    output logic [9:0]  m_step_position
);

    step_entry_t pattern_mem [PATTERN_STEPS];
    step_entry_t rd_data_reg;
    step_entry_t entry0_reg;

    logic [15:0]      max_timeout_reg;
    logic [7:0]       level_max_reg;

    logic             drive_en_reg, drive_en_next;
    logic [7:0]       cur_level_reg, cur_level_next;
    logic [7:0]       def_level_reg, def_level_next;
    logic [7:0]       duty_reg, duty_next;
    logic             one_shot_reg, one_shot_next;
    logic             armed_reg, armed_next;
    logic [15:0]      count_reg, count_next;
    logic [POS_W-1:0] next_step_reg, next_step_next;
    logic [POS_W-1:0] step_count_reg, step_count_next;

    logic             in_xfer;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    step_entry_t      mem_wdata;

    logic             play_req;
    logic [POS_W-1:0] play_pos;
    step_entry_t      play_entry;
    logic [7:0]       play_dur;
    logic [7:0]       play_lvl;
    logic [7:0]       lvl_clamped;
    logic [15:0]      ontime_clamped;

    result_t          result;
    result_t          out_reg, out_next;
    result_t          skid_reg;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             skid_load;
    logic             out_pop;

    assign s_ready = !skid_valid_reg;
    assign in_xfer = s_valid && s_ready;
    assign out_pop = out_valid_reg && m_ready;

    assign mem_we    = in_xfer && (s_req_type == REQ_LOAD)
                       && (32'(s_step_index) < PATTERN_STEPS);
    assign mem_waddr = IDX_W'(s_step_index);
    assign mem_wdata = '{level: s_step_level, duration: s_step_duration};
    // prefetch the entry at the position the player will hold next cycle
    assign mem_raddr = IDX_W'(next_step_next);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pattern_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == mem_raddr)) begin
            rd_data_reg <= mem_wdata;
        end else begin
            rd_data_reg <= pattern_mem[mem_raddr];
        end
        if (mem_we && (mem_waddr == '0)) begin
            entry0_reg <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_timeout_reg <= MAX_TIMEOUT_RST;
            level_max_reg   <= LEVEL_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_TIMEOUT: max_timeout_reg <= cfg_wdata;
                CFG_LEVEL_MAX:   level_max_reg   <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    assign lvl_clamped    = (s_level_value > level_max_reg) ? level_max_reg : s_level_value;
    assign ontime_clamped = (s_on_time_ms > max_timeout_reg) ? max_timeout_reg : s_on_time_ms;

    always_comb begin
        drive_en_next   = drive_en_reg;
        cur_level_next  = cur_level_reg;
        def_level_next  = def_level_reg;
        duty_next       = duty_reg;
        one_shot_next   = one_shot_reg;
        armed_next      = armed_reg;
        count_next      = count_reg;
        next_step_next  = next_step_reg;
        step_count_next = step_count_reg;
        play_req        = 1'b0;
        play_pos        = next_step_reg;
        play_entry      = rd_data_reg;
        play_dur        = '0;
        play_lvl        = '0;

        if (in_xfer) begin
            case (s_req_type)
                REQ_TICK: begin
                    if (armed_reg) begin
                        if (count_reg <= 16'd1) begin
                            armed_next = 1'b0;
                            count_next = '0;
                            if (one_shot_reg) begin
                                one_shot_next = 1'b0;
                                drive_en_next = 1'b0;
                            end
                            play_req = 1'b1;
                        end else begin
                            count_next = count_reg - 16'd1;
                        end
                    end
                end
                REQ_LOAD: begin
                end
                REQ_START: begin
                    step_count_next = (32'(s_seq_length) > PATTERN_STEPS)
                                      ? POS_W'(PATTERN_STEPS) : POS_W'(s_seq_length);
                    next_step_next  = '0;
                    play_pos        = '0;
                    play_entry      = entry0_reg;
                    play_req        = 1'b1;
                end
                REQ_ONESHOT: begin
                    if (s_on_time_ms == '0) begin
                        armed_next    = 1'b0;
                        count_next    = '0;
                        drive_en_next = 1'b0;
                    end else begin
                        cur_level_next = def_level_reg;
                        drive_en_next  = 1'b1;
                        armed_next     = 1'b1;
                        count_next     = ontime_clamped;
                        one_shot_next  = 1'b1;
                    end
                end
                REQ_LEVEL: begin
                    def_level_next = lvl_clamped;
                    cur_level_next = lvl_clamped;
                end
                default: ;
            endcase

            if (play_req && (play_pos < step_count_next)) begin
                next_step_next = play_pos + POS_W'(1);
                play_dur = (16'(play_entry.duration) > max_timeout_reg)
                           ? max_timeout_reg[7:0] : play_entry.duration;
                play_dur = (play_dur > DUR_OFFSET) ? (play_dur - DUR_OFFSET) : '0;
                play_lvl = (play_entry.level > level_max_reg)
                           ? level_max_reg : play_entry.level;
                cur_level_next = play_lvl;
                if (play_lvl != '0) begin
                    drive_en_next = 1'b1;
                end
                armed_next = 1'b1;
                count_next = 16'(play_dur);
            end

            if (drive_en_next) begin
                duty_next = cur_level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_en_reg   <= 1'b0;
            cur_level_reg  <= LEVEL_RST;
            def_level_reg  <= LEVEL_RST;
            duty_reg       <= '0;
            one_shot_reg   <= 1'b0;
            armed_reg      <= 1'b0;
            count_reg      <= '0;
            next_step_reg  <= '0;
            step_count_reg <= '0;
        end else begin
            drive_en_reg   <= drive_en_next;
            cur_level_reg  <= cur_level_next;
            def_level_reg  <= def_level_next;
            duty_reg       <= duty_next;
            one_shot_reg   <= one_shot_next;
            armed_reg      <= armed_next;
            count_reg      <= count_next;
            next_step_reg  <= next_step_next;
            step_count_reg <= step_count_next;
        end
    end

    always_comb begin
        result.motor_on      = drive_en_next;
        result.duty_level    = duty_next;
        result.remaining_ms  = armed_next ? count_next : '0;
        result.step_position = 10'(next_step_next);
    end

    // two-entry output buffer: the skid slot fills only when the head is stalled
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        skid_load       = 1'b0;
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_xfer) begin
            if (!out_valid_reg || out_pop) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (out_pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg <= out_next;
        if (skid_load) begin
            skid_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_motor_on      = out_reg.motor_on;
    assign m_duty_level    = out_reg.duty_level;
    assign m_remaining_ms  = out_reg.remaining_ms;
    assign m_step_position = out_reg.step_position;

    `HPS_ASSERT(a_skid_behind_head, skid_valid_reg |-> out_valid_reg)
    `HPS_ASSERT(a_idle_timer_zero, !armed_reg |-> (count_reg == '0))
    `HPS_ASSERT(a_pos_in_sequence, next_step_reg <= step_count_reg)
    `HPS_ASSERT(a_count_bounded, 32'(step_count_reg) <= PATTERN_STEPS)
    `HPS_ASSERT_NEXT(a_prefetch_fwd, mem_we && (mem_waddr == mem_raddr), rd_data_reg == $past(mem_wdata))

endmodule
